[design/rack_aware_replica_placer_defines.svh]
// Assertion macros shared by the placer's checker.
// Each macro clocks on clk and is disabled while rst_n is low.
`ifndef RACK_AWARE_REPLICA_PLACER_DEFINES_SVH
`define RACK_AWARE_REPLICA_PLACER_DEFINES_SVH

// Same-cycle implication.
`define RARP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RARP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/rarp_pkg.sv]
// Types and status codes of the rack-aware replica placer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rarp_pkg;

  localparam logic [1:0] STAT_OK         = 2'd0;
  localparam logic [1:0] STAT_START_FULL = 2'd1;
  localparam logic [1:0] STAT_RACK_FULL  = 2'd2;
  localparam logic [1:0] STAT_THIRD_FULL = 2'd3;

  typedef struct packed {
    logic [4:0]  start_node;
    logic [15:0] block_number;
  } in_t;

  typedef struct packed {
    logic [15:0] block_number_out;
    logic [1:0]  replica;
    logic [4:0]  node;
    logic [6:0]  slot;
    logic [1:0]  status;
    logic        last;
  } out_t;

endpackage
`default_nettype wire

[design/rarp_front.sv]
// Front end: accepts requests and splits the start node into rack and position.
// Depends on rarp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rarp_front #(
  parameter int NODES_PER_RACK = 6,
  parameter int RACKS          = 3
) (
  input  wire                                  in_valid,
  input  rarp_pkg::in_t                        in_data,
  input  wire                                  q_full,
  output logic                                 in_stall,
  output logic                                 q_push,
  output logic [15:0]                          cmd_blk,
  output logic [$clog2(RACKS)-1:0]             cmd_rack,
  output logic [$clog2(NODES_PER_RACK)-1:0]    cmd_pos
);
  localparam int NC   = NODES_PER_RACK * RACKS;
  localparam int KMAX = 31 / NC;
  localparam int RW   = $clog2(RACKS);
  localparam int PW   = $clog2(NODES_PER_RACK);

  logic [4:0] sub;
  logic [4:0] n0;
  logic [7:0] n0_w;
  logic [7:0] base;
  logic [7:0] pos_w;

  // Reduce the start node into range, then find its rack by compare.
  always_comb begin
    sub = '0;
    for (int k = 1; k <= KMAX; k++) begin
      if (in_data.start_node >= 5'(k * NC)) sub = 5'(k * NC);
    end
    n0   = in_data.start_node - sub;
    n0_w = 8'(n0);
    cmd_rack = '0;
    base     = '0;
    for (int r = 1; r < RACKS; r++) begin
      if (n0_w >= 8'(r * NODES_PER_RACK)) begin
        cmd_rack = RW'(r);
        base     = 8'(r * NODES_PER_RACK);
      end
    end
    pos_w   = n0_w - base;
    cmd_pos = PW'(pos_w);
  end

  assign cmd_blk  = in_data.block_number;
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

endmodule
`default_nettype wire

[design/rarp_fifo.sv]
// Two-entry queue between the front end and the placement sequencer.
// Standalone; width set by the instantiating module.
`timescale 1ns / 1ps
`default_nettype none
module rarp_fifo #(
  parameter int WIDTH = 22
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              push,
  input  wire [WIDTH-1:0]  wr_data,
  input  wire              pop,
  output logic             full,
  output logic             not_empty,
  output logic [WIDTH-1:0] rd_data
);
  logic [WIDTH-1:0] mem_r [2];
  logic             wptr_r, rptr_r;
  logic [1:0]       cnt_r;
  logic [1:0]       cnt_nxt;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign rd_data   = mem_r[rptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 2'd1;
    else if (!push && pop) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) wptr_r <= ~wptr_r;
      if (pop) rptr_r <= ~rptr_r;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= wr_data;
  end

endmodule
`default_nettype wire

[design/rarp_back.sv]
// Placement sequencer: fill-count memory, per-node full flags, result register.
// Depends on rarp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rarp_back #(
  parameter int NODES_PER_RACK = 6,
  parameter int RACKS          = 3,
  parameter int SLOTS_PER_NODE = 64
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                cmd_valid,
  input  wire [15:0]                         cmd_blk,
  input  wire [$clog2(RACKS)-1:0]            cmd_rack,
  input  wire [$clog2(NODES_PER_RACK)-1:0]   cmd_pos,
  output logic                               cmd_pop,
  output logic                               out_valid,
  input  wire                                out_stall,
  output rarp_pkg::out_t                     out_data
);
  localparam int NC = NODES_PER_RACK * RACKS;
  localparam int NW = $clog2(NC);
  localparam int PW = $clog2(NODES_PER_RACK);
  localparam int RW = $clog2(RACKS);
  localparam int CW = $clog2(SLOTS_PER_NODE + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_CHK, ST_UPD} state_t;

  state_t          state_r, state_nxt;
  logic [15:0]     blk_r, blk_nxt;
  logic [RW-1:0]   rack_r, rack_nxt;
  logic [PW-1:0]   pos_r, pos_nxt;
  logic [NW-1:0]   node_r, node_nxt;
  logic [1:0]      rep_r, rep_nxt;
  logic            out_valid_r, out_valid_nxt;
  rarp_pkg::out_t  out_data_r, out_data_nxt;
  logic [NC-1:0]   full_r, full_nxt;
  logic [NC-1:0]   vld_r, vld_nxt;

  logic [CW-1:0]   cnt_mem [NC];
  logic [CW-1:0]   rd_data_r;
  logic            rd_en;
  logic [NW-1:0]   rd_addr;
  logic            wr_en;

  logic                      can_emit;
  logic [NW-1:0]             base_node;
  logic [NODES_PER_RACK-1:0] rack_full;
  logic                      found;
  logic [PW-1:0]             fpos;
  logic [PW:0]               psum;
  logic [RW-1:0]             next_rack;
  logic [NW-1:0]             n1, n2;
  logic [CW-1:0]             cnt, new_cnt;

  assign can_emit  = !out_valid_r || !out_stall;
  assign base_node = NW'(rack_r * NODES_PER_RACK);
  assign rack_full = full_r[base_node +: NODES_PER_RACK];
  assign next_rack = (rack_r == RW'(RACKS - 1)) ? '0 : rack_r + RW'(1);
  assign n1        = base_node + NW'(fpos);
  assign n2        = NW'(next_rack * NODES_PER_RACK) + NW'(pos_r);
  assign cnt       = vld_r[node_r] ? rd_data_r : '0;
  assign new_cnt   = cnt + CW'(1);

  // Nearest non-full node after pos_r in the rack, with wrap; lowest offset wins.
  always_comb begin
    found = 1'b0;
    fpos  = '0;
    psum  = '0;
    for (int i = NODES_PER_RACK - 1; i >= 1; i--) begin
      psum = {1'b0, pos_r} + (PW + 1)'(i);
      if (psum >= (PW + 1)'(NODES_PER_RACK)) psum = psum - (PW + 1)'(NODES_PER_RACK);
      if (!rack_full[psum[PW-1:0]]) begin
        found = 1'b1;
        fpos  = psum[PW-1:0];
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    blk_nxt       = blk_r;
    rack_nxt      = rack_r;
    pos_nxt       = pos_r;
    node_nxt      = node_r;
    rep_nxt       = rep_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    full_nxt      = full_r;
    vld_nxt       = vld_r;
    cmd_pop       = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = node_r;
    wr_en         = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop   = 1'b1;
          blk_nxt   = cmd_blk;
          rack_nxt  = cmd_rack;
          pos_nxt   = cmd_pos;
          node_nxt  = NW'(cmd_rack * NODES_PER_RACK) + NW'(cmd_pos);
          rep_nxt   = 2'd0;
          state_nxt = ST_CHK;
        end
      end
      ST_CHK: begin
        if (rep_r == 2'd1) begin
          if (!found) begin
            if (can_emit) begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = '{block_number_out: blk_r, replica: rep_r, node: 5'd0,
                                slot: 7'd0, status: rarp_pkg::STAT_RACK_FULL, last: 1'b1};
              state_nxt     = ST_IDLE;
            end
          end else begin
            node_nxt  = n1;
            pos_nxt   = fpos;
            rd_en     = 1'b1;
            rd_addr   = n1;
            state_nxt = ST_UPD;
          end
        end else if (full_r[node_r]) begin
          if (can_emit) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{block_number_out: blk_r, replica: rep_r, node: 5'(node_r),
                              slot: 7'd0,
                              status: (rep_r == 2'd0) ? rarp_pkg::STAT_START_FULL
                                                      : rarp_pkg::STAT_THIRD_FULL,
                              last: 1'b1};
            state_nxt     = ST_IDLE;
          end
        end else begin
          rd_en     = 1'b1;
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        if (can_emit) begin
          out_valid_nxt    = 1'b1;
          out_data_nxt     = '{block_number_out: blk_r, replica: rep_r, node: 5'(node_r),
                               slot: 7'(new_cnt), status: rarp_pkg::STAT_OK,
                               last: (rep_r == 2'd2)};
          wr_en            = 1'b1;
          vld_nxt[node_r]  = 1'b1;
          full_nxt[node_r] = (new_cnt == CW'(SLOTS_PER_NODE));
          if (rep_r == 2'd2) begin
            state_nxt = ST_IDLE;
          end else begin
            // After replica 1, aim at the same position in the next rack.
            if (rep_r == 2'd1) node_nxt = n2;
            rep_nxt   = rep_r + 2'd1;
            state_nxt = ST_CHK;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      full_r      <= '0;
      vld_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      full_r      <= full_nxt;
      vld_r       <= vld_nxt;
    end
    blk_r      <= blk_nxt;
    rack_r     <= rack_nxt;
    pos_r      <= pos_nxt;
    node_r     <= node_nxt;
    rep_r      <= rep_nxt;
    out_data_r <= out_data_nxt;
  end

  // Fill-count store; entries not yet written read as zero through vld_r.
  always_ff @(posedge clk) begin
    if (wr_en) cnt_mem[node_r] <= new_cnt;
    if (rd_en) rd_data_r <= cnt_mem[rd_addr];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

[design/rack_aware_replica_placer.sv]
// Rack-aware placer of three block replicas over RACKS x NODES_PER_RACK nodes.
// Input channel in_valid/in_stall/in_data carries a start node and a block
// number; output channel out_valid/out_stall/out_data carries one result per
// placed replica, or an error result that ends the request (last marks the
// final result of each request).
// A two-entry queue parts the front end from the placement sequencer, so
// requests are taken while the sequencer works; in_stall rises once both
// entries are in use.
// Each request passes through the sequencer as a pop, then per replica a full
// check with count-memory read and a count update; an error ends it sooner.
// The sequencer takes a new request only once the last one is done; the
// fill-count memory serves one node per access.
// Out_stall holds the result register and the sequencer waits behind it.
// Reset clears every node's count to zero at once (per-node valid flags) and
// empties the queue; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module rack_aware_replica_placer #(
  parameter int NODES_PER_RACK = 6,
  parameter int RACKS          = 3,
  parameter int SLOTS_PER_NODE = 64
) (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             in_valid,
  output logic            in_stall,
  input  rarp_pkg::in_t   in_data,
  output logic            out_valid,
  input  wire             out_stall,
  output rarp_pkg::out_t  out_data
);
  localparam int RW = $clog2(RACKS);
  localparam int PW = $clog2(NODES_PER_RACK);
  localparam int QW = 16 + RW + PW;

  logic          q_full, q_push, q_pop, q_valid;
  logic [15:0]   f_blk, b_blk;
  logic [RW-1:0] f_rack, b_rack;
  logic [PW-1:0] f_pos, b_pos;
  logic [QW-1:0] q_rd;

  rarp_front #(
    .NODES_PER_RACK (NODES_PER_RACK),
    .RACKS          (RACKS)
  ) u_front (
    .in_valid (in_valid),
    .in_data  (in_data),
    .q_full   (q_full),
    .in_stall (in_stall),
    .q_push   (q_push),
    .cmd_blk  (f_blk),
    .cmd_rack (f_rack),
    .cmd_pos  (f_pos)
  );

  rarp_fifo #(
    .WIDTH (QW)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wr_data   ({f_blk, f_rack, f_pos}),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .rd_data   (q_rd)
  );

  assign {b_blk, b_rack, b_pos} = q_rd;

  rarp_back #(
    .NODES_PER_RACK (NODES_PER_RACK),
    .RACKS          (RACKS),
    .SLOTS_PER_NODE (SLOTS_PER_NODE)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_valid),
    .cmd_blk   (b_blk),
    .cmd_rack  (b_rack),
    .cmd_pos   (b_pos),
    .cmd_pop   (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

[design/rarp_checker.sv]
// Port-level checker for the placer, bound to the top level.
// Depends on rarp_pkg and rack_aware_replica_placer_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "rack_aware_replica_placer_defines.svh"
module rarp_checker (
  input wire            clk,
  input wire            rst_n,
  input wire            in_valid,
  input wire            in_stall,
  input wire            out_valid,
  input wire            out_stall,
  input rarp_pkg::out_t out_data
);
  logic [1:0] exp_rep_r;
  logic [2:0] pend_r;
  logic       in_acc, out_acc, done;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign done    = out_acc && out_data.last;

  // Track the replica expected next and the requests still owed a last result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_rep_r <= 2'd0;
      pend_r    <= 3'd0;
    end else begin
      if (out_acc) exp_rep_r <= out_data.last ? 2'd0 : out_data.replica + 2'd1;
      if (in_acc && !done) pend_r <= pend_r + 3'd1;
      else if (!in_acc && done) pend_r <= pend_r - 3'd1;
    end
  end

  `RARP_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")
  `RARP_ASSERT_IMP(a_rep_order, out_valid, out_data.replica == exp_rep_r, "replica out of order")
  `RARP_ASSERT_IMP(a_no_orphan, out_valid, pend_r != 3'd0, "result without a pending request")

endmodule

bind rack_aware_replica_placer rarp_checker u_rarp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire

[tb/tb_top.sv]
// Self-checking bench for rack_aware_replica_placer: a table of directed items, then
// random items aimed at full nodes and racks, with every result checked in order.
// Depends on rarp_pkg and the placer RTL only.
`timescale 1ns / 1ps
module tb_top;

  localparam int NODES_PER_RACK = 6;
  localparam int RACKS          = 3;
  localparam int SLOTS_PER_NODE = 64;
  localparam int NODE_COUNT     = NODES_PER_RACK * RACKS;

  localparam int RANDOM_ITEMS   = 352;
  localparam int RACK_SWITCH_AT = 220;
  localparam int PRESSURE_AT    = 96;
  localparam int LONG_HOLD      = 300;
  localparam int DRAIN_CYCLES   = 32;

  typedef struct packed {
    logic [4:0]  start_node;
    logic [15:0] block_number;
    logic [1:0]  typed_results;
  } dir_row_t;

  localparam int DIR_N = 18;
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    '{5'd0,  16'hFFFF, 2'd3},
    '{5'd17, 16'h0000, 2'd3},
    '{5'd31, 16'h8000, 2'd3},
    '{5'd18, 16'h5555, 2'd0},
    '{5'd5,  16'hAAAA, 2'd0},
    '{5'd1,  16'h0001, 2'd0},
    '{5'd2,  16'h0002, 2'd0},
    '{5'd4,  16'h0004, 2'd0},
    '{5'd8,  16'h0100, 2'd0},
    '{5'd16, 16'h1000, 2'd0},
    '{5'd11, 16'h7FFF, 2'd0},
    '{5'd12, 16'h1234, 2'd0},
    '{5'd6,  16'hFFFE, 2'd0},
    '{5'd24, 16'h00FF, 2'd0},
    '{5'd30, 16'hFF00, 2'd0},
    '{5'd23, 16'h0F0F, 2'd0},
    '{5'd29, 16'hF0F0, 2'd0},
    '{5'd0,  16'h0000, 2'd0}
  };

  // Results of the first three rows, straight after reset.
  localparam rarp_pkg::out_t DIR_RESULTS [9] = '{
    '{16'hFFFF, 2'd0, 5'd0,  7'd1, rarp_pkg::STAT_OK, 1'b0},
    '{16'hFFFF, 2'd1, 5'd1,  7'd1, rarp_pkg::STAT_OK, 1'b0},
    '{16'hFFFF, 2'd2, 5'd7,  7'd1, rarp_pkg::STAT_OK, 1'b1},
    '{16'h0000, 2'd0, 5'd17, 7'd1, rarp_pkg::STAT_OK, 1'b0},
    '{16'h0000, 2'd1, 5'd12, 7'd1, rarp_pkg::STAT_OK, 1'b0},
    '{16'h0000, 2'd2, 5'd0,  7'd2, rarp_pkg::STAT_OK, 1'b1},
    '{16'h8000, 2'd0, 5'd13, 7'd1, rarp_pkg::STAT_OK, 1'b0},
    '{16'h8000, 2'd1, 5'd14, 7'd1, rarp_pkg::STAT_OK, 1'b0},
    '{16'h8000, 2'd2, 5'd2,  7'd1, rarp_pkg::STAT_OK, 1'b1}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  rarp_pkg::in_t  in_data;
  logic out_valid;
  logic out_stall;
  rarp_pkg::out_t out_data;

  int unsigned    node_fill [NODE_COUNT];
  rarp_pkg::out_t new_placements [$];
  rarp_pkg::out_t placements_due [$];
  int unsigned    misplaced;
  bit             in_no_idle;
  bit             long_hold_req;

  always #5 clk = ~clk;

  rack_aware_replica_placer #(
    .NODES_PER_RACK (NODES_PER_RACK),
    .RACKS          (RACKS),
    .SLOTS_PER_NODE (SLOTS_PER_NODE)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  function automatic rarp_pkg::out_t placement(logic [15:0] blk, logic [1:0] rep,
                                               int unsigned node, int unsigned slot,
                                               logic [1:0] status, logic last);
    rarp_pkg::out_t r;
    r.block_number_out = blk;
    r.replica          = rep;
    r.node             = node[4:0];
    r.slot             = slot[6:0];
    r.status           = status;
    r.last             = last;
    return r;
  endfunction

  // Place one block's replicas on node_fill and leave its results in new_placements.
  function automatic void place_block(rarp_pkg::in_t item);
    int unsigned n0, rack, pos, n1, n2, tries;
    bit found;
    new_placements.delete();
    n0   = item.start_node % NODE_COUNT;
    rack = n0 / NODES_PER_RACK;
    pos  = n0 % NODES_PER_RACK;
    if (node_fill[n0] >= SLOTS_PER_NODE) begin
      new_placements.push_back(placement(item.block_number, 2'd0, n0, 0,
                                         rarp_pkg::STAT_START_FULL, 1'b1));
      return;
    end
    node_fill[n0]++;
    new_placements.push_back(placement(item.block_number, 2'd0, n0, node_fill[n0],
                                       rarp_pkg::STAT_OK, 1'b0));
    found = 1'b0;
    for (tries = 1; tries < NODES_PER_RACK && !found; tries++) begin
      pos = (pos + 1) % NODES_PER_RACK;
      found = node_fill[rack * NODES_PER_RACK + pos] < SLOTS_PER_NODE;
    end
    if (!found) begin
      new_placements.push_back(placement(item.block_number, 2'd1, 0, 0,
                                         rarp_pkg::STAT_RACK_FULL, 1'b1));
      return;
    end
    n1 = rack * NODES_PER_RACK + pos;
    node_fill[n1]++;
    new_placements.push_back(placement(item.block_number, 2'd1, n1, node_fill[n1],
                                       rarp_pkg::STAT_OK, 1'b0));
    // third replica: same position, next rack round
    n2 = ((rack + 1) % RACKS) * NODES_PER_RACK + pos;
    if (node_fill[n2] >= SLOTS_PER_NODE) begin
      new_placements.push_back(placement(item.block_number, 2'd2, n2, 0,
                                         rarp_pkg::STAT_THIRD_FULL, 1'b1));
      return;
    end
    node_fill[n2]++;
    new_placements.push_back(placement(item.block_number, 2'd2, n2, node_fill[n2],
                                       rarp_pkg::STAT_OK, 1'b1));
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic deliver_item(rarp_pkg::in_t item, int typed_first, int typed_n);
    int unsigned gap;
    gap = in_no_idle ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    place_block(item);
    if (typed_n == 0) begin
      foreach (new_placements[k]) placements_due.push_back(new_placements[k]);
    end else begin
      for (int k = 0; k < typed_n; k++) placements_due.push_back(DIR_RESULTS[typed_first + k]);
    end
    @(negedge clk);
  endtask

  function automatic void check_field(string field, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      misplaced++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    rarp_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (placements_due.size() == 0) begin
        $error("result with nothing outstanding: %p", out_data);
        misplaced++;
      end else begin
        want = placements_due.pop_front();
        check_field("block_number_out", want.block_number_out, out_data.block_number_out);
        check_field("replica", want.replica, out_data.replica);
        check_field("node", want.node, out_data.node);
        check_field("slot", want.slot, out_data.slot);
        check_field("status", want.status, out_data.status);
        check_field("last", want.last, out_data.last);
      end
    end
  end

  initial begin : receiver
    int unsigned hold;
    int unsigned taken;
    bit out_no_idle;
    taken = 0;
    out_no_idle = 1'b0;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (taken % 40 == 0) out_no_idle = ($urandom_range(0, 3) == 0);
      hold = out_no_idle ? 0 : $urandom_range(0, 15);
      if (long_hold_req) begin
        hold = LONG_HOLD;
        long_hold_req = 1'b0;
      end
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      taken++;
      @(negedge clk);
    end
  end

  initial begin : stimulus
    rarp_pkg::in_t item;
    int typed_at;
    int unsigned hot_rack;
    misplaced     = 0;
    in_no_idle    = 1'b0;
    long_hold_req = 1'b0;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    foreach (node_fill[n]) node_fill[n] = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    typed_at = 0;
    for (int r = 0; r < DIR_N; r++) begin
      item.start_node   = DIR_ROWS[r].start_node;
      item.block_number = DIR_ROWS[r].block_number;
      deliver_item(item, typed_at, DIR_ROWS[r].typed_results);
      typed_at += DIR_ROWS[r].typed_results;
    end

    // Crowd one rack until it is full, then the rack whose third replicas land in it.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 32 == 0) in_no_idle = (i == PRESSURE_AT) || ($urandom_range(0, 3) == 0);
      if (i == PRESSURE_AT) long_hold_req = 1'b1;
      hot_rack = (i < RACK_SWITCH_AT) ? 1 : 0;
      if ($urandom_range(0, 99) < 85)
        item.start_node = 5'(hot_rack * NODES_PER_RACK + $urandom_range(0, NODES_PER_RACK - 1));
      else
        item.start_node = 5'($urandom_range(0, 31));
      item.block_number = 16'($urandom_range(0, 16'hFFFF));
      deliver_item(item, 0, 0);
    end
    in_valid <= 1'b0;

    while (placements_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (misplaced == 0 && placements_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

[filelist.f]
+incdir+design
design/rarp_pkg.sv
design/rarp_front.sv
design/rarp_fifo.sv
design/rarp_back.sv
design/rack_aware_replica_placer.sv
design/rarp_checker.sv
tb/tb_top.sv
